// ===== rtl/lrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrs_pkg: shared types and constants of the Laplacian RGB stencil filter
// Pixel and work item types, register codes, queue sizes and the per-channel
// four-neighbour Laplacian.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int DIM_MIN      = 3;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

    typedef logic [CHAN_W-1:0]   chan_t;
    typedef logic [COL_W-1:0]    col_t;
    typedef logic [HEIGHT_W-1:0] row_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pix_t;

    // One accepted pixel that releases results, as the back end needs it
    typedef struct packed {
        pix_t pix;       // incoming pixel (down neighbor, or last-row copy)
        pix_t centre;
        pix_t left;
        pix_t right;
        pix_t up;
        logic filt;      // first result is filtered, else a copy of centre
        logic last_row;  // a second result (the pixel itself) follows
        logic row_end;
    } work_t;

    typedef struct packed {
        pix_t pix;
        logic run_last;
        logic frame_done;
    } result_t;

    function automatic chan_t chan_laplace(chan_t l, chan_t r, chan_t u, chan_t d,
                                           chan_t c);
        chan_t sum;
        sum = l + r + u + d - {c[CHAN_W-3:0], 2'b00};
        return sum;
    endfunction

    function automatic pix_t pix_laplace(pix_t l, pix_t r, pix_t u, pix_t d, pix_t c);
        pix_t res;
        res.red   = chan_laplace(l.red,   r.red,   u.red,   d.red,   c.red);
        res.green = chan_laplace(l.green, r.green, u.green, d.green, c.green);
        res.blue  = chan_laplace(l.blue,  r.blue,  u.blue,  d.blue,  c.blue);
        return res;
    endfunction

endpackage

// ===== rtl/laplacian_rgb_stencil_filter.sv =====
// ----------------------------------------------------------------------------
// laplacian_rgb_stencil_filter: four-neighbour Laplacian on an RGB raster
// Top level: front end with line stores, work queue, result back end.
// ----------------------------------------------------------------------------
// Pixels enter in raster order at one per clock while full is low; each channel
// of an interior pixel becomes left + right + up + down - 4*centre modulo 256,
// border pixels are copied. Results run one row behind: the first row gives
// none, middle rows one result per pixel, the last row two (the pixel above,
// then itself), so in the last row each work item holds the single result port
// for both its results. Each pixel costs one write and one read on each of the
// two line-store RAMs, which sets the one-pixel-per-clock intake. After reset
// and after every register write the block refills its neighbor prefetch in the
// states PRIME_READ and PRIME_SHIFT with full high.
// ----------------------------------------------------------------------------
module laplacian_rgb_stencil_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [lrs_pkg::CHAN_W-1:0]     in_red,
    input  logic [lrs_pkg::CHAN_W-1:0]     in_green,
    input  logic [lrs_pkg::CHAN_W-1:0]     in_blue,
    output logic                           empty,
    input  logic                           pop,
    output logic [lrs_pkg::CHAN_W-1:0]     out_red,
    output logic [lrs_pkg::CHAN_W-1:0]     out_green,
    output logic [lrs_pkg::CHAN_W-1:0]     out_blue,
    output logic                           run_last,
    output logic                           frame_done,
    input  logic                           cfg_write,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrs_pkg::CFG_DATA_W-1:0] cfg_data
);

    lrs_pkg::pix_t    in_pix;
    lrs_pkg::work_t   work;
    logic             work_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    lrs_pkg::work_t   q_item;
    lrs_pkg::result_t head;

    assign in_pix.red   = in_red;
    assign in_pix.green = in_green;
    assign in_pix.blue  = in_blue;

    lrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_pix    (in_pix),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .work      (work),
        .work_push (work_push),
        .q_full    (q_full)
    );

    lrs_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (work_push),
        .item_in  (work),
        .full     (q_full),
        .valid    (q_valid),
        .pop      (q_pop),
        .item_out (q_item)
    );

    lrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item       (q_item),
        .item_pop   (q_pop),
        .head       (head),
        .empty      (empty),
        .pop        (pop)
    );

    assign out_red    = head.pix.red;
    assign out_green  = head.pix.green;
    assign out_blue   = head.pix.blue;
    assign run_last   = head.run_last;
    assign frame_done = head.frame_done;

endmodule

// ===== rtl/lrs_ram.sv =====
// ----------------------------------------------------------------------------
// lrs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module lrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/lrs_front.sv =====
// ----------------------------------------------------------------------------
// lrs_front: pixel intake, raster counters and line stores
// Accepts pixels, keeps the two line stores, prefetches the centre, right and
// up neighbors one pixel ahead and classifies each pixel into a work item.
// ----------------------------------------------------------------------------
module lrs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  lrs_pkg::pix_t                 in_pix,
    input  logic                          cfg_write,
    input  logic [lrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lrs_pkg::CFG_DATA_W-1:0] cfg_data,
    output lrs_pkg::work_t                work,
    output logic                          work_push,
    input  logic                          q_full
);

    typedef enum logic [2:0] {
        ST_PRIME_READ  = 3'b001,
        ST_PRIME_SHIFT = 3'b010,
        ST_RUN         = 3'b100
    } prime_state_t;

    prime_state_t state_reg, state_next;

    lrs_pkg::col_t w_last_reg;
    lrs_pkg::row_t h_last_reg;
    lrs_pkg::col_t col_reg;
    lrs_pkg::row_t row_reg;
    lrs_pkg::pix_t cen_reg;
    lrs_pkg::pix_t left_reg;

    lrs_pkg::pix_t mid_rdata;
    lrs_pkg::pix_t up_rdata;
    lrs_pkg::col_t mid_raddr;
    lrs_pkg::col_t up_raddr;
    logic          mid_re;
    logic          up_re;

    logic          accept;
    logic          row_end;
    logic          last_row;
    lrs_pkg::col_t nc;
    lrs_pkg::col_t nnc;

    logic [lrs_pkg::WIDTH_W-1:0]  wv;
    logic [lrs_pkg::HEIGHT_W-1:0] hv;
    lrs_pkg::col_t                w_last_cfg;
    lrs_pkg::row_t                h_last_cfg;

    assign accept = push && (state_reg == ST_RUN) && !q_full;
    assign full   = (state_reg != ST_RUN) || q_full;

    assign row_end  = col_reg >= w_last_reg;
    assign last_row = row_reg >= h_last_reg;
    assign nc       = row_end ? '0 : col_reg + 1'b1;
    assign nnc      = (nc >= w_last_reg) ? '0 : nc + 1'b1;

    // Clamp register values once on write and keep last-index form
    assign wv = cfg_data[lrs_pkg::WIDTH_W-1:0];
    assign hv = cfg_data[lrs_pkg::HEIGHT_W-1:0];

    always_comb
    begin
        priority if (int'(wv) < lrs_pkg::DIM_MIN)
            w_last_cfg = lrs_pkg::COL_W'(lrs_pkg::DIM_MIN - 1);
        else if (int'(wv) > lrs_pkg::MAX_WIDTH)
            w_last_cfg = lrs_pkg::COL_W'(lrs_pkg::MAX_WIDTH - 1);
        else
            w_last_cfg = lrs_pkg::COL_W'(wv - lrs_pkg::WIDTH_W'(1));
    end

    always_comb
    begin
        priority if (int'(hv) < lrs_pkg::DIM_MIN)
            h_last_cfg = lrs_pkg::HEIGHT_W'(lrs_pkg::DIM_MIN - 1);
        else
            h_last_cfg = hv - lrs_pkg::HEIGHT_W'(1);
    end

    // Priming refills centre and up from this column, right from the next one
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_PRIME_READ:  state_next = ST_PRIME_SHIFT;
            ST_PRIME_SHIFT: state_next = ST_RUN;
            ST_RUN:         state_next = ST_RUN;
            default:        state_next = ST_PRIME_READ;
        endcase
        if (cfg_write)
        begin
            state_next = ST_PRIME_READ;
        end
    end

    always_comb
    begin
        mid_re    = 1'b0;
        up_re     = 1'b0;
        mid_raddr = col_reg;
        up_raddr  = col_reg;
        unique case (state_reg)
            ST_PRIME_READ:
            begin
                mid_re = 1'b1;
                up_re  = 1'b1;
            end
            ST_PRIME_SHIFT:
            begin
                // at a row end the next centre is column 0
                mid_re    = 1'b1;
                mid_raddr = nc;
            end
            ST_RUN:
            begin
                mid_re    = accept;
                up_re     = accept;
                mid_raddr = nnc;
                up_raddr  = nc;
            end
            default:
            begin
                mid_re = 1'b0;
                up_re  = 1'b0;
            end
        endcase
    end

    lrs_ram #(
        .WIDTH ($bits(lrs_pkg::pix_t)),
        .DEPTH (lrs_pkg::MAX_WIDTH)
    ) u_mid_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (in_pix),
        .re    (mid_re),
        .raddr (mid_raddr),
        .rdata (mid_rdata)
    );

    lrs_ram #(
        .WIDTH ($bits(lrs_pkg::pix_t)),
        .DEPTH (lrs_pkg::MAX_WIDTH)
    ) u_up_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (cen_reg),
        .re    (up_re),
        .raddr (up_raddr),
        .rdata (up_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_PRIME_READ;
            w_last_reg <= lrs_pkg::COL_W'(lrs_pkg::WIDTH_RESET - 1);
            h_last_reg <= lrs_pkg::HEIGHT_W'(lrs_pkg::HEIGHT_RESET - 1);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && cfg_index == lrs_pkg::REG_IMAGE_WIDTH)
            begin
                w_last_reg <= w_last_cfg;
            end
            if (cfg_write && cfg_index == lrs_pkg::REG_IMAGE_HEIGHT)
            begin
                h_last_reg <= h_last_cfg;
            end
            if (accept)
            begin
                if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept || state_reg == ST_PRIME_SHIFT)
        begin
            cen_reg <= mid_rdata;
        end
        if (accept)
        begin
            left_reg <= cen_reg;
        end
    end

    // First row releases nothing
    assign work_push     = accept && (row_reg != '0);
    assign work.pix      = in_pix;
    assign work.centre   = cen_reg;
    assign work.left     = left_reg;
    assign work.right    = mid_rdata;
    assign work.up       = up_rdata;
    assign work.filt     = !((row_reg == lrs_pkg::HEIGHT_W'(1)) || (col_reg == '0) || row_end);
    assign work.last_row = last_row;
    assign work.row_end  = row_end;

endmodule

// ===== rtl/lrs_cmdq.sv =====
// ----------------------------------------------------------------------------
// lrs_cmdq: work item queue between front and back end
// Small register FIFO so intake and result generation stall independently.
// ----------------------------------------------------------------------------
module lrs_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lrs_pkg::work_t item_in,
    output logic           full,
    output logic           valid,
    input  logic           pop,
    output lrs_pkg::work_t item_out
);

    lrs_pkg::work_t                mem_reg [lrs_pkg::CMDQ_DEPTH];
    logic [lrs_pkg::CMDQ_AW-1:0]   wr_ptr_reg;
    logic [lrs_pkg::CMDQ_AW-1:0]   rd_ptr_reg;
    logic [lrs_pkg::CMDQ_AW:0]     count_reg;
    logic [lrs_pkg::CMDQ_AW:0]     count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full     = count_reg == (lrs_pkg::CMDQ_AW + 1)'(lrs_pkg::CMDQ_DEPTH);
    assign valid    = count_reg != '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign item_out = mem_reg[rd_ptr_reg];

    assign count_next = count_reg + (lrs_pkg::CMDQ_AW + 1)'(do_push)
                      - (lrs_pkg::CMDQ_AW + 1)'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== rtl/lrs_back.sv =====
// ----------------------------------------------------------------------------
// lrs_back: result generation and output queue
// Turns each work item into one or two results (filtered or copied pixel,
// then the last-row copy) and holds them in a small output queue.
// ----------------------------------------------------------------------------
module lrs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  lrs_pkg::work_t   item,
    output logic             item_pop,
    output lrs_pkg::result_t head,
    output logic             empty,
    input  logic             pop
);

    lrs_pkg::work_t   cur_reg;
    logic             cur_valid_reg;
    logic             second_reg;
    lrs_pkg::result_t res;

    lrs_pkg::result_t              oq_reg [lrs_pkg::OUTQ_DEPTH];
    logic [lrs_pkg::OUTQ_AW-1:0]   oq_wr_reg;
    logic [lrs_pkg::OUTQ_AW-1:0]   oq_rd_reg;
    logic [lrs_pkg::OUTQ_AW:0]     oq_count_reg;
    logic [lrs_pkg::OUTQ_AW:0]     oq_count_next;
    logic                          oq_full;
    logic                          out_pop;

    logic emit;
    logic finishing;
    logic take;

    always_comb
    begin
        if (!second_reg)
        begin
            res.pix = cur_reg.filt
                    ? lrs_pkg::pix_laplace(cur_reg.left, cur_reg.right, cur_reg.up,
                                           cur_reg.pix, cur_reg.centre)
                    : cur_reg.centre;
            res.run_last   = !cur_reg.last_row;
            res.frame_done = 1'b0;
        end
        else
        begin
            res.pix        = cur_reg.pix;
            res.run_last   = 1'b1;
            res.frame_done = cur_reg.row_end;
        end
    end

    assign oq_full   = oq_count_reg == (lrs_pkg::OUTQ_AW + 1)'(lrs_pkg::OUTQ_DEPTH);
    assign empty     = oq_count_reg == '0;
    assign out_pop   = pop && !empty;
    assign head      = oq_reg[oq_rd_reg];

    assign emit      = cur_valid_reg && !oq_full;
    assign finishing = emit && (second_reg || !cur_reg.last_row);
    assign take      = !cur_valid_reg || finishing;
    assign item_pop  = take && item_valid;

    assign oq_count_next = oq_count_reg + (lrs_pkg::OUTQ_AW + 1)'(emit)
                         - (lrs_pkg::OUTQ_AW + 1)'(out_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
            oq_wr_reg     <= '0;
            oq_rd_reg     <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            oq_count_reg <= oq_count_next;
            if (emit)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (out_pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            if (take)
            begin
                cur_valid_reg <= item_valid;
                second_reg    <= 1'b0;
            end
            else if (emit)
            begin
                second_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            cur_reg <= item;
        end
        if (emit)
        begin
            oq_reg[oq_wr_reg] <= res;
        end
    end

endmodule

// ===== rtl/lrs_checker.sv =====
// ----------------------------------------------------------------------------
// lrs_checker: port-level checks for the Laplacian stencil filter
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [lrs_pkg::CHAN_W-1:0]    out_red,
    input logic [lrs_pkg::CHAN_W-1:0]    out_green,
    input logic [lrs_pkg::CHAN_W-1:0]    out_blue,
    input logic                          run_last,
    input logic                          frame_done,
    input logic                          cfg_write
);

    // Frame end is always the final result of its transaction
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_done) |-> run_last)
        else $error("frame_done without run_last");

    // A register write forces a prefetch refill, so intake must stall
    a_cfg_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> full)
        else $error("input not stalled after register write");

    // Waiting result holds until popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_red) && $stable(out_green)
                              && $stable(out_blue) && $stable(run_last)
                              && $stable(frame_done)))
        else $error("pending result changed without pop");

endmodule

bind laplacian_rgb_stencil_filter lrs_checker u_lrs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .run_last   (run_last),
    .frame_done (frame_done),
    .cfg_write  (cfg_write)
);

// ===== tb/stencil_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stencil_checker: result checker for the Laplacian RGB stencil filter
// Watches the pixel, result and register channels, keeps its own copy of the
// line stores and counters, predicts each result and compares it in order.
// ----------------------------------------------------------------------------
module stencil_checker
    import lrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [CHAN_W-1:0]     in_red,
    input  logic [CHAN_W-1:0]     in_green,
    input  logic [CHAN_W-1:0]     in_blue,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [CHAN_W-1:0]     out_red,
    input  logic [CHAN_W-1:0]     out_green,
    input  logic [CHAN_W-1:0]     out_blue,
    input  logic                  run_last,
    input  logic                  frame_done,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    checked
);

    pix_t                upper_line [MAX_WIDTH];
    pix_t                middle_line [MAX_WIDTH];
    pix_t                left_pix;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    int                  col_pos;
    int                  row_pos;
    result_t             expected_pixels [$];

    function automatic chan_t laplace_chan(input chan_t l, input chan_t r, input chan_t u,
                                           input chan_t d, input chan_t c);
        logic [9:0] acc;
        acc = 10'(l) + 10'(r) + 10'(u) + 10'(d) - (10'(c) << 2);
        return acc[7:0];
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH %s", msg);
    endtask

    task automatic predict_filtered_pixels(input pix_t pix);
        int      w;
        int      h;
        int      c;
        int      r;
        logic    row_end;
        logic    last_row;
        pix_t    centre;
        pix_t    up;
        pix_t    right;
        pix_t    res;
        result_t item;

        w = (width_reg < DIM_MIN) ? DIM_MIN : int'(width_reg);
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h = (height_reg < DIM_MIN) ? DIM_MIN : int'(height_reg);
        c = col_pos % MAX_WIDTH;
        r = row_pos;
        row_end  = (c >= w - 1);
        last_row = (r >= h - 1);

        centre = middle_line[c];
        up     = upper_line[c];
        right  = row_end ? '0 : middle_line[(c + 1) % MAX_WIDTH];

        // one row behind: this pixel is the down neighbor of the released one
        if (r >= 1)
        begin
            if (r == 1 || c == 0 || row_end)
                res = centre;
            else
            begin
                res.red   = laplace_chan(left_pix.red, right.red, up.red, pix.red,
                                         centre.red);
                res.green = laplace_chan(left_pix.green, right.green, up.green, pix.green,
                                         centre.green);
                res.blue  = laplace_chan(left_pix.blue, right.blue, up.blue, pix.blue,
                                         centre.blue);
            end
            item.pix        = res;
            item.run_last   = !last_row;
            item.frame_done = 1'b0;
            expected_pixels.push_back(item);
            if (last_row)
            begin
                item.pix        = pix;
                item.run_last   = 1'b1;
                item.frame_done = row_end;
                expected_pixels.push_back(item);
            end
        end

        upper_line[c]  = centre;
        middle_line[c] = pix;
        left_pix       = centre;
        if (row_end)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((r + 1) & 16'hffff);
        end
        else
            col_pos = c + 1;
    endtask

    task automatic check_result();
        result_t seen;
        result_t want;

        seen.pix        = {out_red, out_green, out_blue};
        seen.run_last   = run_last;
        seen.frame_done = frame_done;
        checked++;
        if (expected_pixels.size() == 0)
            note_failure($sformatf("result %0d unexpected: rgb=%06h last=%b done=%b",
                                   checked, seen.pix, seen.run_last, seen.frame_done));
        else
        begin
            want = expected_pixels.pop_front();
            if (seen.pix.red !== want.pix.red || seen.pix.green !== want.pix.green
                || seen.pix.blue !== want.pix.blue || seen.run_last !== want.run_last
                || seen.frame_done !== want.frame_done)
                note_failure($sformatf({"result %0d: expected rgb=%06h last=%b done=%b, ",
                                        "got rgb=%06h last=%b done=%b"},
                                       checked, want.pix, want.run_last, want.frame_done,
                                       seen.pix, seen.run_last, seen.frame_done));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_W'(WIDTH_RESET);
            height_reg = HEIGHT_W'(HEIGHT_RESET);
            col_pos    = 0;
            row_pos    = 0;
            left_pix   = '0;
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            expected_pixels.delete();
        end
        else
        begin
            if (pop && !empty)
                check_result();
            if (push && !full)
                predict_filtered_pixels({in_red, in_green, in_blue});
            if (cfg_write)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data[WIDTH_W-1:0];
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = cfg_data[HEIGHT_W-1:0];
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the Laplacian RGB stencil filter
// Streams whole frames of pixels under varying geometry, including extreme
// and out-of-range register values and mid-frame changes, with random idling
// on both queue sides; the checker module predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import lrs_pkg::*;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  push       = 1'b0;
    logic                  pop        = 1'b0;
    logic [CHAN_W-1:0]     in_red     = '0;
    logic [CHAN_W-1:0]     in_green   = '0;
    logic [CHAN_W-1:0]     in_blue    = '0;
    logic                  cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  full;
    logic                  empty;
    logic [CHAN_W-1:0]     out_red;
    logic [CHAN_W-1:0]     out_green;
    logic [CHAN_W-1:0]     out_blue;
    logic                  run_last;
    logic                  frame_done;

    int fail_count;
    int pending;
    int checked;

    int tx_idle_pct = 22;
    int rx_idle_pct = 68;
    // frame position as seen from the sending side
    int trk_col     = 0;
    int trk_row     = 0;
    int trk_w       = WIDTH_RESET;
    int trk_h       = HEIGHT_RESET;
    int pixels_sent = 0;
    int frames_sent = 0;
    int mid_changes = 0;

    laplacian_rgb_stencil_filter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .empty      (empty),
        .pop        (pop),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .run_last   (run_last),
        .frame_done (frame_done),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    stencil_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .empty      (empty),
        .pop        (pop),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .run_last   (run_last),
        .frame_done (frame_done),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic pix_t rand_pix();
        pix_t p;
        p = 24'($urandom);
        if ($urandom_range(0, 7) == 0)
        begin
            p.red   = {8{$urandom_range(0, 1) == 1}};
            p.green = {8{$urandom_range(0, 1) == 1}};
            p.blue  = {8{$urandom_range(0, 1) == 1}};
        end
        return p;
    endfunction

    // called and returns at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        int v;
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        if (idx == REG_IMAGE_WIDTH)
        begin
            v = value & 12'hfff;
            trk_w = (v < DIM_MIN) ? DIM_MIN : (v > MAX_WIDTH) ? MAX_WIDTH : v;
        end
        else
        begin
            v = value & 16'hffff;
            trk_h = (v < DIM_MIN) ? DIM_MIN : v;
        end
    endtask

    task automatic send_pixel(input pix_t p);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push     <= 1'b1;
        in_red   <= p.red;
        in_green <= p.green;
        in_blue  <= p.blue;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        pixels_sent++;
        if (trk_col >= trk_w - 1)
        begin
            trk_col = 0;
            trk_row = (trk_row >= trk_h - 1) ? 0 : trk_row + 1;
        end
        else
            trk_col++;
    endtask

    // hold off the sender until every expected result is out, then let the
    // internal pixel queue settle (first-row pixels release nothing)
    task automatic drain();
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic finish_frame();
        while (trk_col != 0 || trk_row != 0)
            send_pixel(rand_pix());
        frames_sent++;
    endtask

    task automatic run_random_frame();
        int wv;
        int hv;
        int k;
        int pick;

        drain();
        case ($urandom_range(0, 9))
            0:       wv = $urandom_range(0, 2);
            1:       wv = $urandom_range(13, 40);
            default: wv = $urandom_range(3, 12);
        endcase
        hv = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
        write_reg(REG_IMAGE_WIDTH, wv);
        write_reg(REG_IMAGE_HEIGHT, hv);

        send_pixel(rand_pix());
        if ($urandom_range(0, 3) == 0)
        begin
            k = $urandom_range(0, trk_w * trk_h - 3);
            repeat (k) send_pixel(rand_pix());
            drain();
            // width may only shrink mid-frame, or rows ahead would read
            // line-store entries that were never filled
            pick = $urandom_range(0, 2);
            if (pick == 0)
                write_reg(REG_IMAGE_WIDTH, $urandom_range(0, trk_w));
            else if (pick == 1)
                write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, trk_row + 2));
            if (pick != 2)
                mid_changes++;
        end
        finish_frame();
    endtask

    initial
    begin
        int mode_start;
        int wait_cycles;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // smallest frame, out-of-range values; checkerboard gives the interior
        // pixel both the largest negative and largest positive wrap
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 1);
        repeat (9)
            send_pixel(((trk_row + trk_col) % 2 == 0) ? 24'hff00ff : 24'h00ff00);
        frames_sent++;

        // widest and tallest settings, cut back mid-frame
        drain();
        write_reg(REG_IMAGE_WIDTH, 4095);
        write_reg(REG_IMAGE_HEIGHT, 65535);
        repeat (6) send_pixel(rand_pix());
        drain();
        write_reg(REG_IMAGE_WIDTH, 2);
        while (!(trk_row == 2 && trk_col == 1))
            send_pixel(rand_pix());
        drain();
        write_reg(REG_IMAGE_HEIGHT, 0);
        finish_frame();
        mid_changes += 2;

        for (int mode = 0; mode < 3; mode++)
        begin
            tx_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 68 : 0;
            rx_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 22 : 0;
            mode_start  = pixels_sent;
            while (pixels_sent - mode_start < 267)
                run_random_frame();
        end

        push <= 1'b0;
        for (wait_cycles = 0; pending != 0 && wait_cycles < 20000; wait_cycles++)
            @(negedge clk);
        repeat (16) @(negedge clk);

        $display("Run covered %0d pixels in %0d frames, %0d results checked, %0d mid-frame",
                 pixels_sent, frames_sent, checked, mid_changes);
        $display("register changes; %0d mismatches, %0d results never seen",
                 fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lrs_pkg.sv
rtl/lrs_ram.sv
rtl/lrs_front.sv
rtl/lrs_cmdq.sv
rtl/lrs_back.sv
rtl/laplacian_rgb_stencil_filter.sv
rtl/lrs_checker.sv
tb/stencil_checker.sv
tb/testbench.sv
